>>> src/hqrr_pkg.sv
// Shared types and constants of the hierarchical quota round-robin scheduler.
`timescale 1ns / 1ps
package hqrr_pkg;

  localparam int QUOTA_W   = 32;
  localparam int WEIGHT_W  = 16;
  localparam int LEN_W     = 16;
  localparam int BW_W      = 21;
  localparam int ROUND_W   = 16;
  localparam int CCOUNT_W  = 5;
  localparam int RND_CNT_W = 7;
  localparam int DEQ_ROUND_LIMIT = 64;

  localparam logic [LEN_W-1:0] DFLT_LIMIT_RST = 16'd1514;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_ENQUEUE = 2'd1;
  localparam logic [1:0] OP_DEQUEUE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BAD     = 2'd3;

endpackage

>>> src/hqrr_div.sv
// Bit-serial restoring divider that computes the per-round fair share.
`timescale 1ns / 1ps
module hqrr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hqrr_pkg::QUOTA_W-1:0] dividend_i,
  input  logic [hqrr_pkg::BW_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [hqrr_pkg::QUOTA_W-1:0] quot_o
);
  import hqrr_pkg::*;

  localparam int CNT_W = $clog2(QUOTA_W);

  logic             run_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BW_W-1:0]  rem_q;
  logic [BW_W-1:0]  dvs_q;
  logic [QUOTA_W-1:0] quo_q;
  logic [BW_W:0]    trial;
  logic             fits;

  assign trial = {rem_q, quo_q[QUOTA_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QUOTA_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= fits ? BW_W'(trial - {1'b0, dvs_q}) : trial[BW_W-1:0];
      quo_q <= {quo_q[QUOTA_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> src/hierarchical_quota_round_robin_unit.sv
// Top level: class tree, ring, length queues and the operation sequencer.
// Create, enqueue and dequeue step through the sequencer; a refused create, a dropped enqueue and
// a dequeue on an empty ring answer from their first state. An enqueue that turns a leaf busy wakes
// its ancestors level by level. A skipped leaf adds a rotation that climbs the parent chain, a leaf
// going idle walks up level by level, and each share recomputed waits on the divider.
// One item is in flight at a time; busy is high until the result strobe. Reset is asynchronous.
`timescale 1ns / 1ps
module hierarchical_quota_round_robin_unit #(
  parameter int NUM_CLASSES = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  output logic                        done_o,
  input  logic                        cfg_we_i,
  input  logic [hqrr_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic [1:0]                  op_i,
  input  logic [3:0]                  class_index_i,
  input  logic [3:0]                  parent_index_i,
  input  logic                        has_parent_i,
  input  logic [15:0]                 class_weight_in_i,
  input  logic                        own_size_given_i,
  input  logic [15:0]                 size_limit_in_i,
  input  logic [15:0]                 packet_length_i,
  output logic [1:0]                  status_o,
  output logic [3:0]                  sent_class_o,
  output logic [15:0]                 sent_length_o
);
  import hqrr_pkg::*;

  localparam int CIW  = $clog2(NUM_CLASSES);
  localparam int IW   = $clog2(NUM_CLASSES + 1);
  localparam int QPW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW   = QPW + 1;
  localparam int MEMD = NUM_CLASSES * QUEUE_DEPTH;
  localparam int AW   = $clog2(MEMD);
  localparam logic [IW-1:0] NodeNone = IW'(NUM_CLASSES);

  typedef enum logic [4:0] {
    S_IDLE, S_CRE, S_CRE_P, S_CRE_FIN, S_CRE_RA, S_ENQ, S_WA, S_LB_RING, S_LB_RA,
    S_DIV_WAIT, S_LV, S_LI_HEAD, S_LI_DEL, S_LI_RA, S_ROT, S_RF, S_CL, S_CL_PROC,
    S_CL_TQ, S_CL_SS, S_RF_MUL, S_RF_TQ, S_DQ, S_DQ_TOP, S_DQ_CHK, S_DQ_CMP,
    S_DQ_SEND, S_DQ_FIN
  } state_e;

  function automatic logic qpos(input logic [QUOTA_W-1:0] v);
    return !v[QUOTA_W-1] && (v != '0);
  endfunction

  state_e state_q, rot_ret_q, idle_ret_q, div_ret_q;

  // Class table.
  logic                present_q [NUM_CLASSES];
  logic [IW-1:0]       parent_q  [NUM_CLASSES];
  logic [WEIGHT_W-1:0] wgt_q     [NUM_CLASSES];
  logic [LEN_W-1:0]    slim_q    [NUM_CLASSES];
  logic [CCOUNT_W-1:0] ccount_q  [NUM_CLASSES];
  logic [QUOTA_W-1:0]  quota_q   [NUM_CLASSES];
  logic [QUOTA_W-1:0]  fs_q      [NUM_CLASSES];
  logic [BW_W-1:0]     bw_q      [NUM_CLASSES];
  logic [ROUND_W-1:0]  cached_q  [NUM_CLASSES];
  logic [QCW-1:0]      qc_q      [NUM_CLASSES];
  logic [QPW-1:0]      qrd_q     [NUM_CLASSES];
  // Ring of busy leaves, doubly linked; the entry past the last class is the round marker.
  logic [IW-1:0]       rnext_q   [NUM_CLASSES+1];
  logic [IW-1:0]       rprev_q   [NUM_CLASSES+1];
  logic [IW-1:0]       head_q;
  logic [IW-1:0]       root_q;
  logic [ROUND_W-1:0]  round_q;
  logic [RND_CNT_W-1:0] rounds_q;
  logic [LEN_W-1:0]    dflt_lim_q;

  // Item registers.
  logic [1:0]          op_q;
  logic [3:0]          cin_q, pin_q;
  logic                hasp_q;
  logic [WEIGHT_W-1:0] win_q;
  logic [LEN_W-1:0]    lim_q, plen_q, dlen_q;

  // Sequencer working registers.
  logic [CIW-1:0]      cur_q, tgt_q, rf_q, leaf_q, dqc_q, div_tgt_q;
  logic [WEIGHT_W-1:0] pend_q;
  logic [QUOTA_W-1:0]  mul_q;
  logic [LEN_W-1:0]    mem_rdata_q;
  logic [LEN_W-1:0]    lmem [MEMD];

  logic                done_q;
  logic [1:0]          status_q;
  logic [3:0]          sc_q;
  logic [LEN_W-1:0]    sl_q;

  logic [CIW-1:0]      cidx, pidx, head_c, par_cur_c;
  logic [IW-1:0]       par_cur, leaf_n, root_c_n;
  logic [CIW-1:0]      root_c;
  logic                c_in, p_in, cre_ok, enq_ok, par_cur_v, root_v;
  logic [SW-1:0]       enq_sum, rd_nxt;
  logic [QPW-1:0]      enq_slot;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic                mem_we, mem_re;
  logic                div_start, div_done;
  logic [QUOTA_W-1:0]  div_quot;
  logic [QUOTA_W-1:0]  mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [BW_W-1:0]     bw_dec;
  logic                dq_fits;

  assign cidx      = CIW'(cin_q);
  assign pidx      = CIW'(pin_q);
  assign c_in      = 32'(cin_q) < NUM_CLASSES;
  assign p_in      = 32'(pin_q) < NUM_CLASSES;
  assign head_c    = head_q[CIW-1:0];
  assign par_cur   = parent_q[cur_q];
  assign par_cur_v = par_cur != NodeNone;
  assign par_cur_c = par_cur[CIW-1:0];
  assign leaf_n    = IW'(leaf_q);
  assign root_c_n  = root_q;
  assign root_c    = root_c_n[CIW-1:0];
  assign root_v    = root_q != NodeNone;

  assign cre_ok = c_in && !present_q[cidx] &&
                  (hasp_q ? (p_in && present_q[pidx]) : !root_v);
  assign enq_ok = c_in && present_q[cidx] && (ccount_q[cidx] == '0) &&
                  (qc_q[cidx] != QCW'(QUEUE_DEPTH));

  assign enq_sum   = SW'(qrd_q[cidx]) + SW'(qc_q[cidx]);
  assign enq_slot  = (enq_sum >= SW'(QUEUE_DEPTH)) ? QPW'(enq_sum - SW'(QUEUE_DEPTH))
                                                   : QPW'(enq_sum);
  assign mem_waddr = AW'(cidx) * AW'(QUEUE_DEPTH) + AW'(enq_slot);
  assign mem_raddr = AW'(head_c) * AW'(QUEUE_DEPTH) + AW'(qrd_q[head_c]);
  assign mem_we    = (state_q == S_ENQ) && enq_ok;
  assign mem_re    = state_q == S_DQ_CHK;
  assign rd_nxt    = SW'(qrd_q[dqc_q]) + SW'(1);

  assign bw_dec  = bw_q[par_cur_c] - BW_W'(wgt_q[cur_q]);
  // The head packet goes once its length is at most the signed leaf quota.
  assign dq_fits = !quota_q[dqc_q][QUOTA_W-1] &&
                   (quota_q[dqc_q] >= QUOTA_W'(mem_rdata_q));

  assign div_start = ((state_q == S_WA) && (bw_q[cur_q] != '0) && qpos(quota_q[cur_q])) ||
                     ((state_q == S_CL_SS) && (bw_q[cur_q] != '0) && qpos(quota_q[cur_q]));

  assign mul_a = (state_q == S_RF_MUL) ? fs_q[tgt_q] : fs_q[par_cur_c];
  assign mul_b = (state_q == S_RF_MUL) ? wgt_q[rf_q] : wgt_q[cur_q];

  hqrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (quota_q[cur_q]),
    .divisor_i  (bw_q[cur_q]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lmem[mem_waddr] <= plen_q;
    end
    if (mem_re) begin
      mem_rdata_q <= lmem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * QUOTA_W'(mul_b);
    if ((state_q == S_CRE) && cre_ok) begin
      wgt_q[cidx]  <= win_q;
      slim_q[cidx] <= lim_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rot_ret_q  <= S_IDLE;
      idle_ret_q <= S_IDLE;
      div_ret_q  <= S_IDLE;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        present_q[i] <= 1'b0;
        parent_q[i]  <= NodeNone;
        ccount_q[i]  <= '0;
        quota_q[i]   <= '0;
        fs_q[i]      <= '0;
        bw_q[i]      <= '0;
        cached_q[i]  <= '0;
        qc_q[i]      <= '0;
        qrd_q[i]     <= '0;
      end
      for (int i = 0; i <= NUM_CLASSES; i++) begin
        rnext_q[i] <= IW'(i);
        rprev_q[i] <= IW'(i);
      end
      head_q     <= NodeNone;
      root_q     <= NodeNone;
      round_q    <= '0;
      rounds_q   <= '0;
      dflt_lim_q <= DFLT_LIMIT_RST;
      op_q       <= '0;
      cin_q      <= '0;
      pin_q      <= '0;
      hasp_q     <= 1'b0;
      win_q      <= '0;
      lim_q      <= '0;
      plen_q     <= '0;
      dlen_q     <= '0;
      cur_q      <= '0;
      tgt_q      <= '0;
      rf_q       <= '0;
      leaf_q     <= '0;
      dqc_q      <= '0;
      div_tgt_q  <= '0;
      pend_q     <= '0;
      done_q     <= 1'b0;
      status_q   <= ST_OK;
      sc_q       <= '0;
      sl_q       <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        dflt_lim_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q   <= op_i;
            cin_q  <= class_index_i;
            pin_q  <= parent_index_i;
            hasp_q <= has_parent_i;
            win_q  <= class_weight_in_i;
            lim_q  <= own_size_given_i ? size_limit_in_i : dflt_lim_q;
            plen_q <= packet_length_i;
            case (op_i)
              OP_CREATE:  state_q <= S_CRE;
              OP_ENQUEUE: state_q <= S_ENQ;
              OP_DEQUEUE: state_q <= S_DQ;
              default: begin
                done_q   <= 1'b1;
                status_q <= ST_OK;
                sc_q     <= '0;
                sl_q     <= '0;
              end
            endcase
          end
        end
        S_CRE: begin
          if (!cre_ok) begin
            done_q   <= 1'b1;
            status_q <= ST_BAD;
            sc_q     <= '0;
            sl_q     <= '0;
            state_q  <= S_IDLE;
          end else begin
            present_q[cidx] <= 1'b1;
            parent_q[cidx]  <= NodeNone;
            ccount_q[cidx]  <= '0;
            quota_q[cidx]   <= '0;
            fs_q[cidx]      <= '0;
            bw_q[cidx]      <= '0;
            cached_q[cidx]  <= '0;
            qc_q[cidx]      <= '0;
            qrd_q[cidx]     <= '0;
            state_q <= hasp_q ? S_CRE_P : S_CRE_FIN;
          end
        end
        S_CRE_P: begin
          // A leaf that gains its first child drops its queue and leaves the ring.
          if ((ccount_q[pidx] == '0) && (qc_q[pidx] != '0)) begin
            qc_q[pidx]  <= '0;
            qrd_q[pidx] <= '0;
            leaf_q      <= pidx;
            cur_q       <= pidx;
            idle_ret_q  <= S_CRE_FIN;
            state_q     <= S_LV;
          end else begin
            state_q <= S_CRE_FIN;
          end
        end
        S_CRE_FIN: begin
          if (hasp_q) begin
            if (ccount_q[pidx] == '0) begin
              fs_q[pidx]     <= '0;
              bw_q[pidx]     <= '0;
              cached_q[pidx] <= '0;
            end
            ccount_q[pidx] <= ccount_q[pidx] + 1'b1;
            parent_q[cidx] <= IW'(pidx);
          end else begin
            root_q <= IW'(cidx);
          end
          state_q <= S_CRE_RA;
        end
        S_CRE_RA: begin
          if (root_v) begin
            quota_q[root_c] <= quota_q[root_c] + QUOTA_W'(win_q);
          end
          done_q   <= 1'b1;
          status_q <= ST_OK;
          sc_q     <= '0;
          sl_q     <= '0;
          state_q  <= S_IDLE;
        end
        S_ENQ: begin
          if (!enq_ok) begin
            done_q   <= 1'b1;
            status_q <= ST_DROP;
            sc_q     <= '0;
            sl_q     <= '0;
            state_q  <= S_IDLE;
          end else begin
            qc_q[cidx] <= qc_q[cidx] + 1'b1;
            if (qc_q[cidx] == '0) begin
              leaf_q <= cidx;
              if (parent_q[cidx] != NodeNone) begin
                cur_q   <= parent_q[cidx][CIW-1:0];
                pend_q  <= wgt_q[cidx];
                state_q <= S_WA;
              end else begin
                state_q <= S_LB_RING;
              end
            end else begin
              done_q   <= 1'b1;
              status_q <= ST_OK;
              sc_q     <= '0;
              sl_q     <= '0;
              state_q  <= S_IDLE;
            end
          end
        end
        S_WA: begin
          // Walk up while the busy weight is zero; each level adds the child below it.
          if (bw_q[cur_q] != '0) begin
            bw_q[cur_q] <= bw_q[cur_q] + BW_W'(pend_q);
            if (qpos(quota_q[cur_q])) begin
              div_tgt_q <= cur_q;
              div_ret_q <= S_LB_RING;
              state_q   <= S_DIV_WAIT;
            end else begin
              fs_q[cur_q] <= '0;
              state_q     <= S_LB_RING;
            end
          end else begin
            bw_q[cur_q]     <= BW_W'(pend_q);
            cached_q[cur_q] <= round_q;
            if (par_cur_v) begin
              pend_q <= wgt_q[cur_q];
              cur_q  <= par_cur_c;
            end else begin
              state_q <= S_LB_RING;
            end
          end
        end
        S_LB_RING: begin
          rnext_q[leaf_n]          <= head_q;
          rprev_q[leaf_n]          <= rprev_q[head_q];
          rnext_q[rprev_q[head_q]] <= leaf_n;
          rprev_q[head_q]          <= leaf_n;
          state_q <= S_LB_RA;
        end
        S_LB_RA: begin
          if (root_v) begin
            quota_q[root_c] <= quota_q[root_c] + QUOTA_W'(slim_q[leaf_q]);
          end
          done_q   <= 1'b1;
          status_q <= ST_OK;
          sc_q     <= '0;
          sl_q     <= '0;
          state_q  <= S_IDLE;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            fs_q[div_tgt_q] <= div_quot;
            state_q <= div_ret_q;
          end
        end
        S_LV: begin
          // Hand the quota back up; a parent left with no busy weight goes idle as well.
          if (!par_cur_v) begin
            state_q <= S_LI_HEAD;
          end else begin
            quota_q[par_cur_c] <= quota_q[par_cur_c] + quota_q[cur_q];
            quota_q[cur_q]     <= '0;
            bw_q[par_cur_c]    <= bw_dec;
            if (bw_dec == '0) begin
              fs_q[par_cur_c] <= '0;
              cur_q <= par_cur_c;
            end else begin
              state_q <= S_LI_HEAD;
            end
          end
        end
        S_LI_HEAD: begin
          if (head_q == leaf_n) begin
            rot_ret_q <= S_LI_DEL;
            state_q   <= S_ROT;
          end else begin
            state_q <= S_LI_DEL;
          end
        end
        S_LI_DEL: begin
          if (rnext_q[leaf_n] != leaf_n) begin
            rnext_q[rprev_q[leaf_n]] <= rnext_q[leaf_n];
            rprev_q[rnext_q[leaf_n]] <= rprev_q[leaf_n];
            if (head_q == leaf_n) begin
              head_q <= rnext_q[leaf_n];
            end
            rnext_q[leaf_n] <= leaf_n;
            rprev_q[leaf_n] <= leaf_n;
          end
          state_q <= S_LI_RA;
        end
        S_LI_RA: begin
          if (root_v) begin
            quota_q[root_c] <= quota_q[root_c] - QUOTA_W'(slim_q[leaf_q]);
          end
          state_q <= idle_ret_q;
        end
        S_ROT: begin
          head_q <= rnext_q[head_q];
          if (rnext_q[head_q] != NodeNone) begin
            rf_q    <= rnext_q[head_q][CIW-1:0];
            state_q <= S_RF;
          end else begin
            state_q <= rot_ret_q;
          end
        end
        S_RF: begin
          if (parent_q[rf_q] != NodeNone) begin
            tgt_q   <= parent_q[rf_q][CIW-1:0];
            cur_q   <= parent_q[rf_q][CIW-1:0];
            state_q <= S_CL;
          end else begin
            state_q <= rot_ret_q;
          end
        end
        S_CL: begin
          // Climb to the topmost ancestor without a share for this round, settle it, retry.
          if (cached_q[cur_q] == round_q) begin
            state_q <= S_RF_MUL;
          end else if (par_cur_v && (cached_q[par_cur_c] != round_q)) begin
            cur_q <= par_cur_c;
          end else begin
            state_q <= S_CL_PROC;
          end
        end
        S_CL_PROC: begin
          state_q <= par_cur_v ? S_CL_TQ : S_CL_SS;
        end
        S_CL_TQ: begin
          quota_q[cur_q]     <= quota_q[cur_q] + mul_q;
          quota_q[par_cur_c] <= quota_q[par_cur_c] - mul_q;
          state_q <= S_CL_SS;
        end
        S_CL_SS: begin
          cached_q[cur_q] <= round_q;
          cur_q <= tgt_q;
          if (div_start) begin
            div_tgt_q <= cur_q;
            div_ret_q <= S_CL;
            state_q   <= S_DIV_WAIT;
          end else begin
            fs_q[cur_q] <= '0;
            state_q     <= S_CL;
          end
        end
        S_RF_MUL: begin
          state_q <= S_RF_TQ;
        end
        S_RF_TQ: begin
          quota_q[rf_q]  <= quota_q[rf_q] + mul_q;
          quota_q[tgt_q] <= quota_q[tgt_q] - mul_q;
          state_q <= rot_ret_q;
        end
        S_DQ: begin
          if (rnext_q[NodeNone] == NodeNone) begin
            done_q   <= 1'b1;
            status_q <= ST_EMPTY;
            sc_q     <= '0;
            sl_q     <= '0;
            state_q  <= S_IDLE;
          end else begin
            rounds_q <= '0;
            state_q  <= S_DQ_TOP;
          end
        end
        S_DQ_TOP: begin
          if (head_q == NodeNone) begin
            if (rounds_q >= RND_CNT_W'(DEQ_ROUND_LIMIT)) begin
              done_q   <= 1'b1;
              status_q <= ST_EMPTY;
              sc_q     <= '0;
              sl_q     <= '0;
              state_q  <= S_IDLE;
            end else begin
              rounds_q  <= rounds_q + 1'b1;
              round_q   <= round_q + 1'b1;
              rot_ret_q <= S_DQ_CHK;
              state_q   <= S_ROT;
            end
          end else begin
            state_q <= S_DQ_CHK;
          end
        end
        S_DQ_CHK: begin
          if ((head_q == NodeNone) || (qc_q[head_c] == '0)) begin
            done_q   <= 1'b1;
            status_q <= ST_EMPTY;
            sc_q     <= '0;
            sl_q     <= '0;
            state_q  <= S_IDLE;
          end else begin
            dqc_q   <= head_c;
            state_q <= S_DQ_CMP;
          end
        end
        S_DQ_CMP: begin
          if (dq_fits) begin
            quota_q[dqc_q] <= quota_q[dqc_q] - QUOTA_W'(mem_rdata_q);
            dlen_q  <= mem_rdata_q;
            state_q <= S_DQ_SEND;
          end else begin
            rot_ret_q <= S_DQ_TOP;
            state_q   <= S_ROT;
          end
        end
        S_DQ_SEND: begin
          if (root_v) begin
            quota_q[root_c] <= quota_q[root_c] + QUOTA_W'(dlen_q);
          end
          qrd_q[dqc_q] <= (rd_nxt == SW'(QUEUE_DEPTH)) ? '0 : QPW'(rd_nxt);
          qc_q[dqc_q]  <= qc_q[dqc_q] - 1'b1;
          if (qc_q[dqc_q] == QCW'(1)) begin
            leaf_q     <= dqc_q;
            cur_q      <= dqc_q;
            idle_ret_q <= S_DQ_FIN;
            state_q    <= S_LV;
          end else begin
            state_q <= S_DQ_FIN;
          end
        end
        S_DQ_FIN: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          sc_q     <= 4'(dqc_q);
          sl_q     <= dlen_q;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign sent_class_o  = sc_q;
  assign sent_length_o = sl_q;

endmodule

>>> src/hqrr_chk.sv
// Port-level checker for the scheduler and its bind to the top level.
`timescale 1ns / 1ps
module hqrr_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic [1:0]                 status_o,
  input logic [3:0]                 sent_class_o,
  input logic [hqrr_pkg::LEN_W-1:0] sent_length_o
);
  import hqrr_pkg::*;

  // The sequencer is back in idle whenever a result is shown.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted item either starts work or answers at once.
  a_accept_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted item neither started nor answered");

  // Every result belongs to an item in flight or just taken.
  a_done_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) || $past(start)))
    else $error("result without an item");

  // A result that is not OK carries no class and no length.
  a_sent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> ((sent_class_o == '0) && (sent_length_o == '0)))
    else $error("sent fields set on a result that sent nothing");

endmodule

bind hierarchical_quota_round_robin_unit hqrr_chk u_hqrr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .sent_class_o  (sent_class_o),
  .sent_length_o (sent_length_o)
);
